// ===== src/blplm_pkg.sv =====
// ============================================================================
// blplm_pkg
// Shared constants, token types and field widths of the block peak level
// meter.
// ============================================================================
package blplm_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int DB_FRACTION_BITS = 8;
    localparam int LEVEL_BITS       = 17;
    localparam int LOG2_FRAC_BITS   = 16;

    localparam int EXP_W   = $clog2(SAMPLE_BITS);
    localparam int SH_W    = 5;
    localparam int MANT_W  = 31;
    localparam int SQ_W    = 2 * MANT_W;
    localparam int NEG_W   = EXP_W + LOG2_FRAC_BITS;
    localparam int DB_OCT_W = 19;
    localparam int PROD_W  = NEG_W + DB_OCT_W;
    localparam int RND_SH  = 32 - DB_FRACTION_BITS;
    localparam int MAG_W   = PROD_W + 1 - RND_SH;

    localparam logic [DB_OCT_W-1:0] DB_OCT_Q16 = DB_OCT_W'(394566);
    localparam logic [MAG_W-1:0] SIL_MAG = MAG_W'(160 << DB_FRACTION_BITS);
    localparam logic signed [LEVEL_BITS-1:0] SILENCE_DB =
        LEVEL_BITS'(-(160 << DB_FRACTION_BITS));

    localparam int IN_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * LEVEL_BITS + SAMPLE_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        K_NONE,
        K_CLEAR,
        K_RESULT
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [SAMPLE_BITS-1:0] peak;
    } t_blk;

    typedef struct packed {
        t_kind                     kind;
        logic                      zero;
        logic [EXP_W-1:0]          expo;
        logic [LOG2_FRAC_BITS-1:0] frac;
        logic [SAMPLE_BITS-1:0]    peak;
    } t_lg;

endpackage

// ===== src/blplm_peak.sv =====
// ============================================================================
// blplm_peak
// Tracks the largest sample magnitude of the running block and launches a
// token into the level pipeline at block end or on a clear command.
// ============================================================================
module blplm_peak (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic                                   i_cmd,
    input  logic signed [blplm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_last,
    output blplm_pkg::t_blk                        o_blk
);

    logic [blplm_pkg::SAMPLE_BITS-1:0] r_peak, n_peak;
    logic [blplm_pkg::SAMPLE_BITS-1:0] w_mag, w_max;
    blplm_pkg::t_blk                   r_blk, n_blk;

    always_comb begin
        w_mag = i_sample[blplm_pkg::SAMPLE_BITS-1] ?
                blplm_pkg::SAMPLE_BITS'(-i_sample) : blplm_pkg::SAMPLE_BITS'(i_sample);
        w_max = (w_mag > r_peak) ? w_mag : r_peak;
        n_peak     = r_peak;
        n_blk.kind = blplm_pkg::K_NONE;
        n_blk.peak = w_max;
        if (!i_en) begin
            n_blk = r_blk;
        end else if (i_valid) begin
            if (i_cmd) begin
                n_blk.kind = blplm_pkg::K_CLEAR;
            end else if (i_last) begin
                n_blk.kind = blplm_pkg::K_RESULT;
                n_peak     = '0;
            end else begin
                n_peak = w_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= '0;
            r_blk.kind <= blplm_pkg::K_NONE;
            r_blk.peak <= '0;
        end else begin
            r_peak <= n_peak;
            r_blk  <= n_blk;
        end
    end

    assign o_blk = r_blk;

endmodule

// ===== src/blplm_log2.sv =====
// ============================================================================
// blplm_log2
// Normalizes the block peak and extracts the fraction bits of its base-2
// logarithm by repeated squaring, one bit per pipeline stage.
// ============================================================================
module blplm_log2 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  blplm_pkg::t_blk i_blk,
    output blplm_pkg::t_lg  o_lg
);

    localparam int N = blplm_pkg::LOG2_FRAC_BITS;

    blplm_pkg::t_lg                   r_st [0:N];
    logic [blplm_pkg::MANT_W-1:0]     r_m  [0:N-1];
    logic [blplm_pkg::EXP_W-1:0]      w_e;
    logic [blplm_pkg::SH_W-1:0]       w_sh;
    logic [blplm_pkg::MANT_W-1:0]     w_m;
    logic [blplm_pkg::SQ_W-1:0]       w_sq [1:N];
    logic [31:0]                      w_t  [1:N];

    always_comb begin
        w_e = '0;
        for (int i = 0; i < blplm_pkg::SAMPLE_BITS; i++) begin
            if (i_blk.peak[i]) begin
                w_e = blplm_pkg::EXP_W'(i);
            end
        end
        w_sh = blplm_pkg::SH_W'(30) - blplm_pkg::SH_W'(w_e);
        w_m  = blplm_pkg::MANT_W'(i_blk.peak) << w_sh;
        for (int k = 1; k <= N; k++) begin
            w_sq[k] = blplm_pkg::SQ_W'(r_m[k-1]) * blplm_pkg::SQ_W'(r_m[k-1]);
            w_t[k]  = w_sq[k][blplm_pkg::SQ_W-1:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_st[k].kind <= blplm_pkg::K_NONE;
            end
        end else if (i_en) begin
            r_st[0].kind <= i_blk.kind;
            r_st[0].zero <= (i_blk.peak == '0);
            r_st[0].expo <= w_e;
            r_st[0].frac <= '0;
            r_st[0].peak <= i_blk.peak;
            r_m[0]       <= w_m;
            for (int k = 1; k <= N; k++) begin
                r_st[k].kind <= r_st[k-1].kind;
                r_st[k].zero <= r_st[k-1].zero;
                r_st[k].expo <= r_st[k-1].expo;
                r_st[k].frac <= {r_st[k-1].frac[N-2:0], w_t[k][31]};
                r_st[k].peak <= r_st[k-1].peak;
            end
            for (int k = 1; k < N; k++) begin
                r_m[k] <= w_t[k][31] ? w_t[k][31:1] : w_t[k][30:0];
            end
        end
    end

    assign o_lg = r_st[N];

endmodule

// ===== src/blplm_db.sv =====
// ============================================================================
// blplm_db
// Scales the base-2 logarithm to dBFS, keeps the maximum hold level and
// holds the result in the output register.
// ============================================================================
module blplm_db (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  blplm_pkg::t_lg                           i_lg,
    input  logic                                     i_tready,
    output logic                                     o_en,
    output logic                                     o_valid,
    output logic signed [blplm_pkg::LEVEL_BITS-1:0]  o_current_db,
    output logic signed [blplm_pkg::LEVEL_BITS-1:0]  o_max_db,
    output logic [blplm_pkg::SAMPLE_BITS-1:0]        o_peak
);

    blplm_pkg::t_kind                         r_kind;
    logic                                     r_zero;
    logic [blplm_pkg::PROD_W-1:0]             r_prod;
    logic [blplm_pkg::SAMPLE_BITS-1:0]        r_peak;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  r_max;
    logic                                     r_out_valid;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  r_out_cur;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  r_out_max;
    logic [blplm_pkg::SAMPLE_BITS-1:0]        r_out_peak;

    logic                                     w_en;
    logic [blplm_pkg::EXP_W-1:0]              w_oct;
    logic [blplm_pkg::NEG_W-1:0]              w_neg;
    logic [blplm_pkg::PROD_W-1:0]             w_prod;
    logic [blplm_pkg::PROD_W:0]               w_rnd;
    logic [blplm_pkg::MAG_W-1:0]              w_mag;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  w_level;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  w_newmax;

    always_comb begin
        w_en   = (r_kind != blplm_pkg::K_RESULT) || !r_out_valid || i_tready;
        w_oct  = blplm_pkg::EXP_W'(blplm_pkg::SAMPLE_BITS - 1) - i_lg.expo;
        w_neg  = {w_oct, blplm_pkg::LOG2_FRAC_BITS'(0)} - blplm_pkg::NEG_W'(i_lg.frac);
        w_prod = blplm_pkg::PROD_W'(w_neg) * blplm_pkg::PROD_W'(blplm_pkg::DB_OCT_Q16);
        w_rnd  = (blplm_pkg::PROD_W + 1)'(r_prod)
               + (blplm_pkg::PROD_W + 1)'(1 << (31 - blplm_pkg::DB_FRACTION_BITS));
        w_mag  = w_rnd[blplm_pkg::PROD_W:blplm_pkg::RND_SH];
        if (r_zero || (w_mag > blplm_pkg::SIL_MAG)) begin
            w_level = blplm_pkg::SILENCE_DB;
        end else begin
            w_level = blplm_pkg::LEVEL_BITS'(0) - blplm_pkg::LEVEL_BITS'(w_mag);
        end
        w_newmax = (w_level > r_max) ? w_level : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= blplm_pkg::K_NONE;
            r_max       <= blplm_pkg::SILENCE_DB;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_kind <= i_lg.kind;
                r_zero <= i_lg.zero;
                r_prod <= w_prod;
                r_peak <= i_lg.peak;
                if (r_kind == blplm_pkg::K_CLEAR) begin
                    r_max <= blplm_pkg::SILENCE_DB;
                end else if (r_kind == blplm_pkg::K_RESULT) begin
                    r_max      <= w_newmax;
                    r_out_cur  <= w_level;
                    r_out_max  <= w_newmax;
                    r_out_peak <= r_peak;
                end
            end
            if (w_en && (r_kind == blplm_pkg::K_RESULT)) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_en         = w_en;
    assign o_valid      = r_out_valid;
    assign o_current_db = r_out_cur;
    assign o_max_db     = r_out_max;
    assign o_peak       = r_out_peak;

`ifndef SYNTH
    a_max_not_below_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_max >= r_out_cur))
        else $error("held maximum is below the current level");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_cur <= 0) && (r_out_cur >= blplm_pkg::SILENCE_DB)))
        else $error("current level out of range");

    a_clear_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && (r_kind == blplm_pkg::K_CLEAR)) |=> (r_max == blplm_pkg::SILENCE_DB))
        else $error("clear did not reset the held maximum");

    a_silent_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_peak == '0)) |-> (r_out_cur == blplm_pkg::SILENCE_DB))
        else $error("silent block does not report silence");
`endif

endmodule

// ===== src/block_peak_level_meter_db_unit.sv =====
// ============================================================================
// block_peak_level_meter_db_unit
// Block peak level meter in dBFS with maximum hold.
//
// Channel  Dir  Signals                 Contents
// s_axis   in   tdata, tuser, tlast     sample, clear command, block end
// m_axis   out  tdata                   current_db, max_db, peak_magnitude
//
// One sample or clear request is taken every cycle unless the input stalls.
// A block result passes the peak register, the normalizing register, the 16
// squaring stages of the logarithm and the dB and output registers to m_axis.
// Synchronous active-low reset clears the peak, the held maximum and all tokens.
// Input stalls only while a result waits in the final stage and the output
// register holds an untaken result.
// ============================================================================
module block_peak_level_meter_db_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [blplm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // sample
    input  logic                                s_axis_tuser,  // cmd
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [blplm_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // current_db, max_db,
                                                               // peak_magnitude
);

    logic                                     w_en;
    blplm_pkg::t_blk                          w_blk;
    blplm_pkg::t_lg                           w_lg;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  w_cur;
    logic signed [blplm_pkg::LEVEL_BITS-1:0]  w_max;
    logic [blplm_pkg::SAMPLE_BITS-1:0]        w_peak;

    blplm_peak u_peak (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_cmd    (s_axis_tuser),
        .i_sample ($signed(s_axis_tdata[blplm_pkg::SAMPLE_BITS-1:0])),
        .i_last   (s_axis_tlast),
        .o_blk    (w_blk)
    );

    blplm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_blk   (w_blk),
        .o_lg    (w_lg)
    );

    blplm_db u_db (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lg         (w_lg),
        .i_tready     (m_axis_tready),
        .o_en         (w_en),
        .o_valid      (m_axis_tvalid),
        .o_current_db (w_cur),
        .o_max_db     (w_max),
        .o_peak       (w_peak)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = blplm_pkg::OUT_DATA_W'({w_peak, w_max, w_cur});

endmodule
